>>> sv/bfra_pkg.sv
`timescale 1ns / 1ps
package bfra_pkg;

  localparam int unsigned DataW = 16;

  typedef enum logic {
    FMT_BF16 = 1'b0,
    FMT_FP16 = 1'b1
  } fmt_t;

  // operand after widening to a common internal form
  typedef struct packed {
    logic        sign;
    logic        is_inf;
    logic        is_nan;
    logic [9:0]  exp;   // biased, fp32 bias, 1..254 for finite nonzero
    logic [23:0] mant;  // hidden bit included, zero means value zero
  } unp_t;

  // sum after alignment and add, before normalisation
  typedef struct packed {
    logic        sign;
    logic        is_inf;
    logic        is_nan;
    logic        zero_sign;
    logic [9:0]  exp;
    logic [27:0] mag;   // 24+1 integer bits, guard, round, sticky
  } sum_t;

  // widen a 16-bit pattern to fp32 bits
  function automatic logic [31:0] to_f32(input logic [15:0] h, input fmt_t fmt);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  lz;
    logic [10:0] mn;
    logic [7:0]  ex;
    logic        found;
    e = h[14:10];
    m = h[9:0];
    lz = 4'd0;
    found = 1'b0;
    mn = 11'd0;
    ex = 8'd0;
    if (fmt == FMT_BF16) begin
      to_f32 = {h, 16'h0000};
    end else if (e == 5'h1f) begin
      to_f32 = {h[15], 8'hff, m, 13'd0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) begin
        to_f32 = {h[15], 31'd0};
      end else begin
        for (int i = 9; i >= 0; i--) begin
          if (!found && m[i]) begin
            found = 1'b1;
            lz = 4'(9 - i);
          end
        end
        mn = {1'b0, m} << (lz + 4'd1);
        ex = 8'd113 - 8'(lz) - 8'd1;
        to_f32 = {h[15], ex, mn[9:0], 13'd0};
      end
    end else begin
      to_f32 = {h[15], 8'(e) + 8'd112, m, 13'd0};
    end
  endfunction

  function automatic unp_t unpack32(input logic [31:0] f);
    unp_t u;
    u.sign = f[31];
    u.is_inf = (f[30:23] == 8'hff) && (f[22:0] == 23'd0);
    u.is_nan = (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
    if (f[30:23] == 8'd0) begin
      u.exp = 10'd1;
      u.mant = {1'b0, f[22:0]};
    end else begin
      u.exp = {2'b00, f[30:23]};
      u.mant = {1'b1, f[22:0]};
    end
    return u;
  endfunction

endpackage

>>> sv/bfra_if.sv
`timescale 1ns / 1ps
interface bfra_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] accum_value;
  logic [15:0] contribution;
  logic        is_first;
  modport source (output valid, accum_value, contribution, is_first, input ready);
  modport sink (input valid, accum_value, contribution, is_first, output ready);
endinterface

interface bfra_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] new_accum;
  modport source (output valid, new_accum, input ready);
  modport sink (input valid, new_accum, output ready);
endinterface

interface bfra_cfg_if;
  logic valid;
  logic ready;
  logic wire_format;
  modport source (output valid, wire_format, input ready);
  modport sink (input valid, wire_format, output ready);
endinterface

>>> sv/bfra_align_add.sv
`timescale 1ns / 1ps
// align the smaller operand and add or subtract magnitudes
module bfra_align_add
  import bfra_pkg::*;
(
  input  unp_t a,
  input  unp_t b,
  output sum_t s
);
  logic        swap;
  unp_t        x, y;
  logic [9:0]  d;
  logic [50:0] ys;
  logic [26:0] ya;
  logic        sticky;
  logic [27:0] xm, ym;

  always_comb begin
    swap = ({b.exp, b.mant} > {a.exp, a.mant});
    x = swap ? b : a;
    y = swap ? a : b;
    d = x.exp - y.exp;
    ys = {y.mant, 27'd0} >> ((d > 10'd27) ? 10'd27 : d);
    ya = ys[50:24];
    sticky = (ys[23:0] != 24'd0);
    xm = {1'b0, x.mant, 3'b000};
    ym = {1'b0, ya[26:1], ya[0] | sticky};
    s.sign = x.sign;
    s.exp = x.exp;
    s.is_nan = a.is_nan || b.is_nan || (a.is_inf && b.is_inf && (a.sign != b.sign));
    s.is_inf = a.is_inf || b.is_inf;
    if (a.is_inf) s.sign = a.sign;
    else if (b.is_inf) s.sign = b.sign;
    s.zero_sign = a.sign & b.sign;
    if (x.sign == y.sign) s.mag = xm + ym;
    else s.mag = xm - ym;
  end
endmodule

>>> sv/bfra_round.sv
`timescale 1ns / 1ps
// normalise and round to fp32
module bfra_round
  import bfra_pkg::*;
(
  input  sum_t        s,
  output logic [31:0] f
);
  logic [4:0]  lz;
  logic        found;
  logic [27:0] nm;
  logic signed [11:0] e;
  logic [27:0] den;
  logic [24:0] v;
  logic        rb, st;
  logic [8:0]  sh;

  always_comb begin
    lz = 5'd0;
    found = 1'b0;
    sh = 9'd0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && s.mag[i]) begin
        found = 1'b1;
        lz = 5'(27 - i);
      end
    end
    // leading one lands at bit 26 for the nominal exponent
    e = $signed({2'b00, s.exp}) + 12'sd1 - $signed({7'd0, lz});
    nm = s.mag << lz;
    den = nm;
    if (e < 12'sd1) begin
      sh = 9'(12'sd1 - e);
      den = (sh > 9'd27) ? {27'd0, nm != 28'd0} : ((nm >> sh) | {27'd0, 1'b0});
      if (sh <= 9'd27) den[0] = den[0] | ((nm & ((28'd1 << sh) - 28'd1)) != 28'd0);
      e = 12'sd0;
    end
    // den[27:4] mantissa, den[3] round, den[2:0] sticky
    rb = den[3];
    st = den[2:0] != 3'd0;
    v = {1'b0, den[27:4]} + 25'((rb && (st || den[4])) ? 1 : 0);
    if (e == 12'sd0 && v[23]) e = 12'sd1;
    if (v[24]) begin
      v = v >> 1;
      e = e + 12'sd1;
    end
    if (s.is_nan) f = 32'h7fc00000;
    else if (s.is_inf) f = {s.sign, 8'hff, 23'd0};
    else if (!found) f = {s.zero_sign, 31'd0};
    else if (e >= 12'sd255) f = {s.sign, 8'hff, 23'd0};
    else f = {s.sign, e[7:0], v[22:0]};
  end
endmodule

// narrow an fp32 sum to the selected 16-bit format
module bfra_narrow
  import bfra_pkg::*;
(
  input  logic [31:0] f,
  input  fmt_t        fmt,
  output logic [15:0] res
);
  logic        is_nan;
  logic signed [11:0] he;
  logic [10:0] hv;
  logic [23:0] mant;
  logic [24:0] msk;
  logic [24:0] hr, hh;
  logic [4:0]  hsh;
  logic [31:0] rr;

  always_comb begin
    is_nan = (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
    rr = f + 32'h8000;
    res = rr[31:16];
    he = $signed({4'd0, f[30:23]}) - 12'sd112;
    hv = 11'd0;
    mant = {1'b1, f[22:0]};
    msk = 25'd0; hr = 25'd0; hh = 25'd0; hsh = 5'd0;
    if (fmt == FMT_FP16) begin
      if (is_nan) res = 16'h7e00;
      else if (f[30:23] == 8'hff || he >= 12'sd31) res = {f[31], 15'h7c00};
      else if (f[30:23] == 8'd0) res = {f[31], 15'd0};
      else if (he >= 12'sd1) begin
        res = {f[31], 15'({he[4:0], f[22:13]})};
        if (f[12:0] > 13'h1000 || (f[12:0] == 13'h1000 && f[13]))
          res = {f[31], 15'({he[4:0], f[22:13]}) + 15'd1};
      end else if (12'sd14 - he > 12'sd24) res = {f[31], 15'd0};
      else begin
        hsh = 5'(12'sd14 - he);
        hr = {1'b0, mant} >> hsh;
        msk = (25'd1 << hsh) - 25'd1;
        hh = 25'd1 << (hsh - 5'd1);
        hv = hr[10:0];
        if (({1'b0, mant} & msk) > hh || ((({1'b0, mant} & msk) == hh) && hv[0]))
          hv = hv + 11'd1;
        res = {f[31], 4'd0, hv};
      end
    end
  end
endmodule

>>> sv/bf16_fp16_reduce_accumulate.sv
`timescale 1ns / 1ps
// Element-wise reduce-accumulate for bfloat16 or IEEE half buffers. One item
// can enter per cycle, unless the result side stalls, through a four-stage
// pipeline (widen, align and add, normalise and round to fp32, narrow); its
// result passes the registers a1_r/b1_r, s2_r, fp3_r and r4_r in that order
// before it is offered. A stall on the result side holds the whole pipeline,
// and an empty last stage lets it advance. With is_first set the contribution
// is passed through. Write wire_format only while no item is in flight.
module bf16_fp16_reduce_accumulate
  import bfra_pkg::*;
(
  input logic clk,
  input logic rst_n,
  bfra_cfg_if.sink cfg,
  bfra_in_if.sink  in_ch,
  bfra_out_if.source out_ch
);
  fmt_t        fmt_r;
  logic [3:0]  vld_r;
  logic        adv;
  unp_t        a1_r, b1_r;
  logic        f1_r, f2_r, f3_r;
  logic [15:0] c1_r, c2_r, c3_r;
  sum_t        s_nxt, s2_r;
  logic [31:0] fp_nxt, fp3_r;
  logic [15:0] r_nxt, r4_r;

  assign cfg.ready = 1'b1;
  assign adv = !vld_r[3] || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld_r[3];
  assign out_ch.new_accum = r4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_BF16;
      vld_r <= 4'd0;
    end else begin
      if (cfg.valid) fmt_r <= fmt_t'(cfg.wire_format);
      if (adv) vld_r <= {vld_r[2:0], in_ch.valid};
    end
  end

  bfra_align_add u_add (.a(a1_r), .b(b1_r), .s(s_nxt));
  bfra_round u_rnd (.s(s2_r), .f(fp_nxt));
  bfra_narrow u_nrw (.f(fp3_r), .fmt(fmt_r), .res(r_nxt));

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r <= unpack32(to_f32(in_ch.accum_value, fmt_r));
      b1_r <= unpack32(to_f32(in_ch.contribution, fmt_r));
      c1_r <= in_ch.contribution;
      f1_r <= in_ch.is_first;
      s2_r <= s_nxt;
      c2_r <= c1_r;
      f2_r <= f1_r;
      fp3_r <= fp_nxt;
      c3_r <= c2_r;
      f3_r <= f2_r;
      r4_r <= f3_r ? c3_r : r_nxt;
    end
  end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb
  import bfra_pkg::*;
();

  typedef struct {
    logic [15:0] accum;
    logic [15:0] contrib;
    logic        first;
  } elem_t;

  logic clk;
  logic rst_n;

  bfra_in_if  in_ch ();
  bfra_out_if out_ch ();
  bfra_cfg_if cfg ();

  bf16_fp16_reduce_accumulate dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  elem_t       pend_q[$];
  logic [15:0] accum_q[$];
  fmt_t        cur_fmt;
  int          errors;
  int          n_in;
  int          n_out;
  int          send_idle;
  int          recv_idle;
  int          hold_cnt;
  int          stall_cycles;
  logic        in_fire;
  logic        pressure_req;
  logic        pressure_done;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // fp32 add, round to nearest even, subnormals kept
  function automatic logic [31:0] fp32_add(input logic [31:0] x, input logic [31:0] y);
    logic        sx, sy, sr, nx, ny, ix, iy;
    int          ex, ey, er, d;
    logic [27:0] mx, my, mag, t;
    logic [31:0] tmp;
    logic [24:0] rm;
    logic        up;
    nx = (x[30:23] == 8'hff) && (x[22:0] != 0);
    ny = (y[30:23] == 8'hff) && (y[22:0] != 0);
    ix = (x[30:23] == 8'hff) && (x[22:0] == 0);
    iy = (y[30:23] == 8'hff) && (y[22:0] == 0);
    if (nx || ny) return 32'h7fc00000;
    if (ix && iy) return (x[31] != y[31]) ? 32'h7fc00000 : x;
    if (ix) return x;
    if (iy) return y;
    ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
    mx = {1'b0, x[30:23] != 0, x[22:0], 3'b000};
    my = {1'b0, y[30:23] != 0, y[22:0], 3'b000};
    // put the larger magnitude first
    if (ex < ey || (ex == ey && mx < my)) begin
      tmp = x; x = y; y = tmp;
      d = ex; ex = ey; ey = d;
      t = mx; mx = my; my = t;
    end
    sx = x[31];
    sy = y[31];
    d = ex - ey;
    if (d > 27) t = (my != 0) ? 28'd1 : 28'd0;
    else t = (my >> d) | 28'((my & ((28'd1 << d) - 28'd1)) != 0);
    sr = sx;
    if (sx == sy) mag = mx + t;
    else mag = mx - t;
    if (mag == 0) return (sx != sy) ? 32'h0 : {sx, 31'd0};
    er = ex;
    if (mag[27]) begin
      mag = (mag >> 1) | 28'(mag[0]);
      er++;
    end
    while (!mag[26] && er > 1) begin
      mag = mag << 1;
      er--;
    end
    up = mag[2] && (mag[3] || mag[1:0] != 0);
    rm = {1'b0, mag[26:3]} + 25'(up);
    if (rm[24]) begin
      rm = rm >> 1;
      er++;
    end
    if (er >= 255) return {sr, 8'hff, 23'd0};
    return {sr, rm[23] ? 8'(er) : 8'd0, rm[22:0]};
  endfunction

  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic [31:0] s;
    logic [7:0]  ex;
    logic [10:0] m;
    s = {h[15], 31'd0};
    m = {1'b0, h[9:0]};
    if (h[14:10] == 5'h1f) return s | 32'h7f800000 | {9'd0, h[9:0], 13'd0};
    if (h[14:10] == 0) begin
      if (m == 0) return s;
      ex = 8'd113;
      while (!m[10]) begin
        m = m << 1;
        ex--;
      end
      return s | {1'b0, ex, m[9:0], 13'd0};
    end
    return s | {1'b0, 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
  endfunction

  function automatic logic [15:0] f32_to_half(input logic [31:0] f);
    logic [15:0] s;
    logic [31:0] mant, v, r, hf;
    int          he, sh;
    s = {f[31], 15'd0};
    if (f[30:23] == 8'hff) return s | 16'h7c00;
    if (f[30:23] == 0) return s;
    he = int'(f[30:23]) - 112;
    if (he >= 31) return s | 16'h7c00;
    if (he >= 1) begin
      v = (32'(he) << 10) | 32'(f[22:13]);
      r = 32'(f[12:0]);
      if (r > 32'h1000 || (r == 32'h1000 && v[0])) v++;
      return s | v[15:0];
    end
    mant = {9'd1, f[22:0]};
    sh = 14 - he;
    if (sh > 24) return s;
    v = mant >> sh;
    r = mant & ((32'd1 << sh) - 1);
    hf = 32'd1 << (sh - 1);
    if (r > hf || (r == hf && v[0])) v++;
    return s | v[15:0];
  endfunction

  function automatic logic [15:0] accum_predict(input elem_t e, input fmt_t fmt);
    logic [31:0] sum;
    if (e.first) return e.contrib;
    if (fmt == FMT_BF16) begin
      sum = fp32_add({e.accum, 16'h0}, {e.contrib, 16'h0});
      if (sum[30:23] == 8'hff && sum[22:0] != 0) sum = 32'h7fc00000;
      sum = sum + 32'h8000;
      return sum[31:16];
    end
    sum = fp32_add(half_to_f32(e.accum), half_to_f32(e.contrib));
    if (sum[30:23] == 8'hff && sum[22:0] != 0) return 16'h7e00;
    return f32_to_half(sum);
  endfunction

  // biased towards cancellation, tiny and huge values
  function automatic elem_t rand_elem();
    elem_t e;
    int    k;
    e.accum = 16'($urandom);
    e.contrib = 16'($urandom);
    e.first = ($urandom_range(9) == 0);
    k = $urandom_range(99);
    if (k < 25) begin
      e.contrib = {~e.accum[15], e.accum[14:4], 4'($urandom)};
    end else if (k < 40) begin
      e.accum[14:9] = 6'($urandom_range(3));
      e.contrib[14:9] = 6'($urandom_range(3));
    end else if (k < 50) begin
      e.accum[14:10] = 5'h1e;
      e.contrib[14:10] = 5'($urandom_range(31, 28));
    end
    return e;
  endfunction

  task automatic add_elem(input logic [15:0] a, input logic [15:0] b, input logic f);
    elem_t e;
    e.accum = a;
    e.contrib = b;
    e.first = f;
    pend_q.push_back(e);
  endtask

  task automatic load_directed();
    add_elem(16'h0000, 16'h0000, 1'b0);
    add_elem(16'h8000, 16'h8000, 1'b0);
    add_elem(16'h0000, 16'h8000, 1'b0);
    add_elem(16'h3c00, 16'hbc00, 1'b0);
    add_elem(16'h3f80, 16'hbf80, 1'b0);
    add_elem(16'h7f80, 16'hff80, 1'b0);
    add_elem(16'h7c00, 16'hfc00, 1'b0);
    add_elem(16'h7f80, 16'h3f80, 1'b0);
    add_elem(16'h7c00, 16'h3c00, 1'b0);
    add_elem(16'h7fc1, 16'h3c00, 1'b0);
    add_elem(16'hfe01, 16'h0001, 1'b0);
    add_elem(16'h7f7f, 16'h7f7f, 1'b0);
    add_elem(16'h7bff, 16'h7bff, 1'b0);
    add_elem(16'h7bff, 16'h0400, 1'b0);
    add_elem(16'h0001, 16'h0001, 1'b0);
    add_elem(16'h0001, 16'h8000, 1'b0);
    add_elem(16'h03ff, 16'h0001, 1'b0);
    add_elem(16'h0080, 16'h8001, 1'b0);
    add_elem(16'hffff, 16'hffff, 1'b0);
    add_elem(16'h1234, 16'h7fff, 1'b1);
    add_elem(16'hffff, 16'hfe01, 1'b1);
    add_elem(16'h0000, 16'h0000, 1'b1);
  endtask

  task automatic write_format(input fmt_t f);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.wire_format <= f;
    do @(posedge clk); while (!cfg.ready);
    cur_fmt = f;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic run_phase(input fmt_t f, input int s_idle, input int r_idle, input logic press);
    write_format(f);
    send_idle = s_idle;
    recv_idle = r_idle;
    load_directed();
    for (int i = 0; i < 465; i++) pend_q.push_back(rand_elem());
    if (press) pressure_req = 1'b1;
    wait (pend_q.size() == 0 && !in_ch.valid && accum_q.size() == 0);
    repeat (6) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_ch.accum_value <= pend_q[0].accum;
        in_ch.contribution <= pend_q[0].contrib;
        in_ch.is_first <= pend_q[0].first;
        in_ch.valid <= 1'b1;
        void'(pend_q.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (pressure_req && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_cnt = 300;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      elem_t e;
      e.accum = in_ch.accum_value;
      e.contrib = in_ch.contribution;
      e.first = in_ch.is_first;
      accum_q.push_back(accum_predict(e, cur_fmt));
      n_in++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (accum_q.size() == 0) begin
        $display("%0t: unexpected item new_accum=%h", $realtime, out_ch.new_accum);
        errors++;
      end else begin
        if (out_ch.new_accum !== accum_q[0]) begin
          $display("%0t: new_accum mismatch expected %h actual %h",
                   $realtime, accum_q[0], out_ch.new_accum);
          errors++;
        end
        void'(accum_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) ||
        (pend_q.size() == 0 && accum_q.size() == 0 && !in_ch.valid && !cfg.valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 5000) begin
        $display("%0t: no progress, %0d items outstanding", $realtime, accum_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    errors = 0;
    n_in = 0;
    n_out = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_cnt = 0;
    stall_cycles = 0;
    in_fire = 1'b0;
    pressure_req = 1'b0;
    pressure_done = 1'b0;
    cur_fmt = FMT_BF16;
    in_ch.valid = 1'b0;
    in_ch.accum_value = 16'h0;
    in_ch.contribution = 16'h0;
    in_ch.is_first = 1'b0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.wire_format = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_phase(FMT_FP16, 31, 87, 1'b0);
    run_phase(FMT_BF16, 87, 31, 1'b0);
    run_phase(FMT_FP16, 0, 0, 1'b0);
    run_phase(FMT_BF16, 0, 0, 1'b1);
    repeat (10) @(posedge clk);
    $display("Covered %0d items in and %0d out over both formats,", n_in, n_out);
    $display("with specials, subnormals, cancellation, pass-through and a long output stall.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bfra_pkg.sv
sv/bfra_if.sv
sv/bfra_align_add.sv
sv/bfra_round.sv
sv/bf16_fp16_reduce_accumulate.sv
tb/sv/tb.sv
